// ----- rtl/mgj_pkg.sv -----
`timescale 1ns / 1ps
package mgj_pkg;
  localparam int Dim = 4;
  localparam int FracBits = 16;
  localparam int Cells = Dim * Dim;
  localparam int CellW = $clog2(Cells);
  localparam int DimW = $clog2(Dim);
  localparam int DataW = 32;
  localparam int QueueDepth = 2;

  typedef logic signed [DataW-1:0] data_t;

  typedef struct packed {
    logic  valid;
    data_t data;
  } elem_t;

  localparam logic signed [DataW-1:0] MaxVal = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] MinVal = {1'b1, {(DataW-1){1'b0}}};
endpackage

// ----- rtl/mgj_divider.sv -----
`timescale 1ns / 1ps
module mgj_divider
  import mgj_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  data_t num,
  input  data_t den,
  output logic  done,
  output data_t quo,
  output logic  sat
);
  localparam int NumW = DataW + FracBits;
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] dividend;
  logic [DataW:0]  rem;
  logic [DataW-1:0] dmag;
  logic            neg;
  logic            busy;
  logic [CntW-1:0] cnt;
  logic [DataW+1:0] trial;
  logic [NumW:0]   qfull;
  logic [NumW:0]   qsigned;

  assign trial = {rem, dividend[NumW-1]} - {2'b00, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CntW'(NumW);
        neg <= num[DataW-1] ^ den[DataW-1];
        dividend <= {(num[DataW-1] ? DataW'(-num) : DataW'(num)), {FracBits{1'b0}}};
        dmag <= den[DataW-1] ? DataW'(-den) : DataW'(den);
        rem <= '0;
      end else if (busy) begin
        if (!trial[DataW+1]) rem <= trial[DataW:0];
        else rem <= {rem[DataW-1:0], dividend[NumW-1]};
        dividend <= {dividend[NumW-2:0], ~trial[DataW+1]};
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign qfull = {1'b0, dividend};
  assign qsigned = neg ? -qfull : qfull;
  always_comb begin
    sat = 1'b0;
    quo = qsigned[DataW-1:0];
    if (!neg && qfull > {{(NumW-DataW+1){1'b0}}, MaxVal}) begin
      sat = 1'b1;
      quo = MaxVal;
    end else if (neg && qfull > (NumW+1)'(65'h80000000)) begin
      sat = 1'b1;
      quo = MinVal;
    end
  end
endmodule

// ----- rtl/mgj_front.sv -----
`timescale 1ns / 1ps
module mgj_front
  import mgj_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  valid,
  output logic  stall,
  input  data_t element,
  output elem_t q_out,
  input  logic  q_pop,
  output logic  q_last
);
  elem_t q [QueueDepth];
  logic  [CellW-1:0] pos [QueueDepth];
  logic  [1:0] count;
  logic  [CellW-1:0] load_count;
  logic  push;

  assign stall = (count == 2'(QueueDepth));
  assign push = valid && !stall;
  assign q_out = q[0];
  assign q_last = (pos[0] == CellW'(Cells - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      load_count <= '0;
      q[0].valid <= 1'b0;
      q[1].valid <= 1'b0;
    end else begin
      if (push) load_count <= load_count + 1'b1;
      case ({push, q_pop && count != 0})
        2'b10: begin
          if (count == 0) begin
            q[0] <= '{1'b1, element};
            pos[0] <= load_count;
          end else begin
            q[1] <= '{1'b1, element};
            pos[1] <= load_count;
          end
          count <= count + 1'b1;
        end
        2'b01: begin
          q[0] <= q[1];
          pos[0] <= pos[1];
          q[1].valid <= 1'b0;
          count <= count - 1'b1;
        end
        2'b11: begin
          if (count == 1) begin
            q[0] <= '{1'b1, element};
            pos[0] <= load_count;
          end else begin
            q[0] <= q[1];
            pos[0] <= pos[1];
            q[1] <= '{1'b1, element};
            pos[1] <= load_count;
          end
        end
        default: begin
        end
      endcase
    end
  end
endmodule

// ----- rtl/mgj_back.sv -----
`timescale 1ns / 1ps
module mgj_back
  import mgj_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  elem_t q_in,
  input  logic  q_last,
  output logic  q_pop,
  output logic  valid,
  input  logic  stall,
  output data_t inverse_element,
  output logic  last_element,
  output logic  singular,
  output logic  saturated
);
  typedef enum logic [3:0] {
    S_LOAD, S_SEARCH, S_SWAP, S_DIV_START, S_DIV_WAIT, S_ELIM_MUL, S_ELIM_SUB,
    S_EMIT
  } state_t;

  state_t state;
  data_t wm [Cells];
  data_t im [Cells];
  logic [CellW-1:0] ld;
  logic [DimW-1:0] ci, rj, kk, prow;
  logic [DataW:0] best;
  logic mat_sel;
  logic sat_seen, sing;
  logic [CellW-1:0] oi;
  data_t factor;
  logic signed [2*DataW-1:0] prod;
  logic div_start, div_done, div_sat;
  data_t div_num, div_q, piv;

  mgj_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(piv),
    .done(div_done), .quo(div_q), .sat(div_sat)
  );

  function automatic logic [CellW-1:0] at(input logic [DimW-1:0] r,
                                          input logic [DimW-1:0] c);
    return {r, c};
  endfunction

  function automatic logic [DataW:0] mag(input data_t v);
    logic signed [DataW:0] w;
    w = {v[DataW-1], v};
    return w[DataW] ? (DataW+1)'(-w) : w;
  endfunction

  data_t cur_b, cur_a;
  logic signed [2*DataW-1:0] fl;
  logic signed [2*DataW-1:0] diff;

  assign cur_b = mat_sel ? im[at(ci, kk)] : wm[at(ci, kk)];
  assign cur_a = mat_sel ? im[at(rj, kk)] : wm[at(rj, kk)];
  assign div_num = mat_sel ? im[at(ci, kk)] : wm[at(ci, kk)];
  assign div_start = (state == S_DIV_START);
  assign fl = prod >>> FracBits;
  assign diff = {{DataW{cur_a[DataW-1]}}, cur_a} - fl;
  assign q_pop = (state == S_LOAD) && q_in.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      valid <= 1'b0;
      ld <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (q_in.valid) begin
            wm[ld] <= q_in.data;
            ld <= ld + 1'b1;
            if (q_last) begin
              ld <= '0;
              for (int n = 0; n < Cells; n++)
                im[n] <= (n / Dim == n % Dim) ? DataW'(1 << FracBits) : '0;
              ci <= '0;
              rj <= '0;
              sat_seen <= 1'b0;
              sing <= 1'b0;
              state <= S_SEARCH;
              best <= '0;
              prow <= '0;
            end
          end else if (ld == '0) begin
            ld <= '0;
          end
        end
        S_SEARCH: begin
          if (rj >= ci && mag(wm[at(rj, ci)]) > best || rj == ci) begin
            best <= mag(wm[at(rj, ci)]);
            prow <= rj;
          end
          if (rj == DimW'(Dim - 1)) begin
            state <= S_SWAP;
          end
          rj <= rj + 1'b1;
        end
        S_SWAP: begin
          if (best == '0) begin
            sing <= 1'b1;
            oi <= '0;
            state <= S_EMIT;
          end else begin
            for (int c = 0; c < Dim; c++) begin
              wm[at(ci, DimW'(c))] <= wm[at(prow, DimW'(c))];
              wm[at(prow, DimW'(c))] <= wm[at(ci, DimW'(c))];
              im[at(ci, DimW'(c))] <= im[at(prow, DimW'(c))];
              im[at(prow, DimW'(c))] <= im[at(ci, DimW'(c))];
            end
            piv <= wm[at(prow, ci)];
            kk <= '0;
            mat_sel <= 1'b0;
            state <= S_DIV_START;
          end
        end
        S_DIV_START: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            if (mat_sel) im[at(ci, kk)] <= div_q;
            else wm[at(ci, kk)] <= div_q;
            if (div_sat) sat_seen <= 1'b1;
            state <= S_DIV_START;
            if (mat_sel) begin
              mat_sel <= 1'b0;
              kk <= kk + 1'b1;
              if (kk == DimW'(Dim - 1)) begin
                rj <= (ci == '0) ? DimW'(1) : '0;
                kk <= '0;
                factor <= wm[at((ci == '0) ? DimW'(1) : '0, ci)];
                state <= S_ELIM_MUL;
              end
            end else begin
              mat_sel <= 1'b1;
            end
          end
        end
        S_ELIM_MUL: begin
          prod <= factor * cur_b;
          state <= S_ELIM_SUB;
        end
        S_ELIM_SUB: begin
          if (diff > $signed({{DataW{MaxVal[DataW-1]}}, MaxVal})) begin
            sat_seen <= 1'b1;
            if (mat_sel) im[at(rj, kk)] <= MaxVal; else wm[at(rj, kk)] <= MaxVal;
          end else if (diff < $signed({{DataW{MinVal[DataW-1]}}, MinVal})) begin
            sat_seen <= 1'b1;
            if (mat_sel) im[at(rj, kk)] <= MinVal; else wm[at(rj, kk)] <= MinVal;
          end else begin
            if (mat_sel) im[at(rj, kk)] <= diff[DataW-1:0];
            else wm[at(rj, kk)] <= diff[DataW-1:0];
          end
          state <= S_ELIM_MUL;
          if (!mat_sel) begin
            mat_sel <= 1'b1;
          end else begin
            mat_sel <= 1'b0;
            kk <= kk + 1'b1;
            if (kk == DimW'(Dim - 1)) begin
              kk <= '0;
              if (rj == DimW'(Dim - 1) || (rj == DimW'(Dim - 2) && ci == DimW'(Dim - 1)))
              begin
                if (ci == DimW'(Dim - 1)) begin
                  oi <= '0;
                  state <= S_EMIT;
                end else begin
                  ci <= ci + 1'b1;
                  rj <= ci + 1'b1;
                  best <= '0;
                  state <= S_SEARCH;
                end
              end else begin
                rj <= (rj + 1'b1 == ci) ? rj + 2'd2 : rj + 1'b1;
                factor <= wm[at((rj + 1'b1 == ci) ? rj + 2'd2 : rj + 1'b1, ci)];
              end
            end
          end
        end
        S_EMIT: begin
          if (!valid || !stall) begin
            if (valid && last_element) begin
              valid <= 1'b0;
              state <= S_LOAD;
            end else begin
              valid <= 1'b1;
              inverse_element <= sing ? '0 : im[oi];
              last_element <= (oi == CellW'(Cells - 1));
              singular <= sing;
              saturated <= sat_seen;
              oi <= oi + 1'b1;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

// ----- rtl/matrix4_gauss_jordan_inverse_top.sv -----
`timescale 1ns / 1ps
// channel  signals                                   handshake
// in       element[31:0]                             in_valid / in_stall
// out      inverse_element, last_element, singular,   out_valid / out_stall
//          saturated
// Each 16th element starts an inversion: a 48-step restoring divider runs
// 32 divisions and a multiply/subtract pair 96 eliminations; a zero pivot ends it early.
// Then 16 words leave, one per cycle when out_stall is low.
// A 2-deep queue takes input words while the back end works.
// rst is synchronous and clears control state only.
module matrix4_gauss_jordan_inverse_top
  import mgj_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  data_t element,
  output logic  out_valid,
  input  logic  out_stall,
  output data_t inverse_element,
  output logic  last_element,
  output logic  singular,
  output logic  saturated
);
  elem_t q;
  logic  q_pop, q_last;

  mgj_front u_front (
    .clk(clk), .rst(rst), .valid(in_valid), .stall(in_stall), .element(element),
    .q_out(q), .q_pop(q_pop), .q_last(q_last)
  );

  mgj_back u_back (
    .clk(clk), .rst(rst), .q_in(q), .q_last(q_last), .q_pop(q_pop),
    .valid(out_valid), .stall(out_stall), .inverse_element(inverse_element),
    .last_element(last_element), .singular(singular), .saturated(saturated)
  );
endmodule
